### rtl/core/rdfsmc_pkg.sv
// Shared constants, types and helpers of the random maze carver.
package rdfsmc_pkg;

   localparam int MAX_SIDE  = 64;
   localparam int SIDE_W    = $clog2(MAX_SIDE);
   localparam int CELL_W    = 2 * SIDE_W;
   localparam int CELLS     = MAX_SIDE * MAX_SIDE;
   localparam int COUNT_W   = CELL_W + 1;
   localparam int CFG_W     = 7;
   localparam int POS_W     = 6;
   localparam int TAG_W     = 4;

   localparam logic [TAG_W-1:0] TAG_CLEAR = '0;
   localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
   localparam logic [TAG_W-1:0] TAG_LAST  = '1;

   // Register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // Direction codes
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic                tag_we;
      logic [CELL_W-1:0]   tag_waddr;
      logic [TAG_W-1:0]    tag_wdata;
      logic [CELL_W-1:0]   tag_raddr;
      logic                ord_we;
      logic [CELL_W-1:0]   ord_waddr;
      logic [CELL_W-1:0]   ord_wdata;
      logic [CELL_W-1:0]   ord_raddr;
   } mem_cmd_type;

   function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      begin
         if (v < CFG_W'(2)) r = CFG_W'(2);
         else if (v > CFG_W'(MAX_SIDE)) r = CFG_W'(MAX_SIDE);
         else r = v;
         return r;
      end
   endfunction

endpackage

### rtl/core/random_dfs_maze_carver_top.sv
// Random depth-first maze carver: control, walker state and result register.
//
// Usage: write maze_width (index 0) and maze_height (index 1) on the csr
// channel while idle; csr_ready is always high. Send a request item with
// req_func = start to begin a maze at cell (0,0), then one item per random
// direction with req_func = step. Each step that moves the walker gives one
// rsp item with the cell and side of the removed wall; rsp_last marks the
// item that visits the final cell, after which steps are ignored until the
// next start. Other steps give no item.
// Sequence: a start is taken in the idle state. A step whose neighbor is
// outside the grid stays in idle when not all directions are tried, and goes
// to the jump state when they are; a neighbor inside the grid is looked up
// in the visited map in the check state, which goes on to the jump state
// when it is visited and all directions are tried. A result item is loaded
// into the output register from the check state.
// The visited map is tagged with a 4-bit epoch; after reset, on the 16th
// start and on every 15th start after it, a clearing pass over all 4096
// map entries runs, during which req_stall stays high. A result waits in
// the output register while rsp_stall is high; a step that needs to emit
// waits behind it.
module random_dfs_maze_carver_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [1:0]                      req_random_dir,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rdfsmc_pkg::POS_W-1:0]    rsp_cell_x,
   output logic [rdfsmc_pkg::POS_W-1:0]    rsp_cell_y,
   output logic [1:0]                      rsp_wall_dir,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [rdfsmc_pkg::CFG_W-1:0]    csr_data
);
   import rdfsmc_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_CHECK = 4'b0100,
      S_JUMP  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    width_ff, width_in;
   logic [CFG_W-1:0]    height_ff, height_in;
   logic [TAG_W-1:0]    epoch_ff, epoch_in;
   logic [CELL_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                start_pend_ff, start_pend_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  back_ff, back_in;
   logic [SIDE_W-1:0]   col_ff, col_in;
   logic [SIDE_W-1:0]   row_ff, row_in;
   logic [3:0]          tried_ff, tried_in;
   logic                running_ff, running_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [SIDE_W-1:0]   nc_ff, nc_in;
   logic [SIDE_W-1:0]   nr_ff, nr_in;
   logic [1:0]          dir_ff, dir_in;
   logic [POS_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]    rsp_y_ff, rsp_y_in;
   logic [1:0]          rsp_dir_ff, rsp_dir_in;
   logic                rsp_last_ff, rsp_last_in;

   mem_cmd_type         cmd;
   logic [TAG_W-1:0]    tag_rdata;
   logic [CELL_W-1:0]   ord_rdata;

   logic [CFG_W-1:0]    w_side, h_side;
   logic [2*CFG_W-1:0]  total;
   logic [SIDE_W:0]     nc_c, nr_c;
   logic                inside_c;
   logic [3:0]          tried_next;
   logic [COUNT_W:0]    back_plus2;
   logic [COUNT_W-1:0]  jump_idx;
   logic                bump;
   logic [COUNT_W-1:0]  count_inc;
   logic                done_c;
   logic                can_load;
   logic                accept;
   logic                unvisited;
   logic                emit;

   rdfsmc_store u_store (
      .clock     (clock),
      .cmd       (cmd),
      .tag_rdata (tag_rdata),
      .ord_rdata (ord_rdata)
   );

   assign csr_ready    = 1'b1;
   assign req_stall    = (state_ff != S_IDLE);
   assign accept       = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_x   = rsp_x_ff;
   assign rsp_cell_y   = rsp_y_ff;
   assign rsp_wall_dir = rsp_dir_ff;
   assign rsp_last     = rsp_last_ff;
   assign can_load     = !rsp_valid_ff || !rsp_stall;

   assign w_side = clamp_side(width_ff);
   assign h_side = clamp_side(height_ff);
   assign total  = w_side * h_side;

   // Neighbor of the current cell in the requested direction
   always_comb begin
      nc_c     = {1'b0, col_ff};
      nr_c     = {1'b0, row_ff};
      inside_c = 1'b0;
      case (req_random_dir)
         DIR_UP: begin
            if (row_ff != '0) begin
               nr_c     = {1'b0, row_ff} - (SIDE_W+1)'(1);
               inside_c = 1'b1;
            end
         end
         DIR_DOWN: begin
            nr_c     = {1'b0, row_ff} + (SIDE_W+1)'(1);
            inside_c = 1'b1;
         end
         DIR_LEFT: begin
            if (col_ff != '0) begin
               nc_c     = {1'b0, col_ff} - (SIDE_W+1)'(1);
               inside_c = 1'b1;
            end
         end
         default: begin
            nc_c     = {1'b0, col_ff} + (SIDE_W+1)'(1);
            inside_c = 1'b1;
         end
      endcase
      if (nc_c >= (SIDE_W+1)'(w_side) || nr_c >= (SIDE_W+1)'(h_side)) begin
         inside_c = 1'b0;
      end
   end

   assign tried_next = tried_ff | (4'b0001 << req_random_dir);

   // Back-jump target and offset bump
   assign back_plus2 = {1'b0, back_ff} + (COUNT_W+1)'(2);
   assign jump_idx   = ({1'b0, count_ff} >= back_plus2) ?
                       COUNT_W'({1'b0, count_ff} - back_plus2) : '0;
   assign bump       = (count_ff != '0) &&
                       (back_plus2 < ({1'b0, count_ff} - (COUNT_W+1)'(1)));

   assign count_inc = (count_ff < COUNT_W'(CELLS)) ? count_ff + COUNT_W'(1) : count_ff;
   assign done_c    = ({1'b0, count_inc} >= total);
   assign unvisited = (tag_rdata != epoch_ff);
   assign emit      = (state_ff == S_CHECK) && unvisited && can_load;

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      epoch_in      = epoch_ff;
      clr_addr_in   = clr_addr_ff;
      start_pend_in = start_pend_ff;
      count_in      = count_ff;
      back_in       = back_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      tried_in      = tried_ff;
      running_in    = running_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      nc_in         = nc_ff;
      nr_in         = nr_ff;
      dir_in        = dir_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_last_in   = rsp_last_ff;

      cmd           = '0;
      cmd.tag_raddr = {nr_ff, nc_ff};
      cmd.ord_raddr = jump_idx[CELL_W-1:0];

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WIDTH:  width_in  = csr_data;
            REG_HEIGHT: height_in = csr_data;
            default:    width_in  = width_ff;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            cmd.tag_we    = 1'b1;
            cmd.tag_waddr = clr_addr_ff;
            cmd.tag_wdata = (clr_addr_ff == '0 && start_pend_ff) ? TAG_FIRST : TAG_CLEAR;
            clr_addr_in   = clr_addr_ff + CELL_W'(1);
            if (clr_addr_ff == CELL_W'(CELLS - 1)) begin
               epoch_in      = start_pend_ff ? TAG_FIRST : TAG_CLEAR;
               start_pend_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.tag_raddr = {nr_c[SIDE_W-1:0], nc_c[SIDE_W-1:0]};
            if (accept) begin
               if (req_func == FUNC_START) begin
                  count_in      = COUNT_W'(1);
                  back_in       = '0;
                  col_in        = '0;
                  row_in        = '0;
                  tried_in      = '0;
                  running_in    = 1'b1;
                  cmd.ord_we    = 1'b1;
                  cmd.ord_waddr = '0;
                  cmd.ord_wdata = '0;
                  if (epoch_ff == TAG_LAST) begin
                     // Epochs exhausted: sweep the map, mark the origin as its first entry
                     start_pend_in = 1'b1;
                     clr_addr_in   = '0;
                     state_in      = S_CLEAR;
                  end else begin
                     epoch_in      = epoch_ff + TAG_W'(1);
                     cmd.tag_we    = 1'b1;
                     cmd.tag_waddr = '0;
                     cmd.tag_wdata = epoch_ff + TAG_W'(1);
                  end
               end else if (running_ff) begin
                  tried_in = tried_next;
                  dir_in   = req_random_dir;
                  nc_in    = nc_c[SIDE_W-1:0];
                  nr_in    = nr_c[SIDE_W-1:0];
                  if (inside_c) begin
                     state_in = S_CHECK;
                  end else if (tried_next == 4'hF) begin
                     state_in = S_JUMP;
                  end
               end
            end
         end
         S_CHECK: begin
            if (unvisited) begin
               if (can_load) begin
                  cmd.tag_we    = 1'b1;
                  cmd.tag_waddr = {nr_ff, nc_ff};
                  cmd.tag_wdata = epoch_ff;
                  cmd.ord_we    = (count_ff < COUNT_W'(CELLS));
                  cmd.ord_waddr = count_ff[CELL_W-1:0];
                  cmd.ord_wdata = {nr_ff, nc_ff};
                  count_in      = count_inc;
                  back_in       = '0;
                  tried_in      = '0;
                  col_in        = nc_ff;
                  row_in        = nr_ff;
                  running_in    = !done_c;
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = POS_W'(col_ff);
                  rsp_y_in      = POS_W'(row_ff);
                  rsp_dir_in    = dir_ff;
                  rsp_last_in   = done_c;
                  state_in      = S_IDLE;
               end
               // else hold and re-read the same entry until the output frees
            end else if (tried_ff == 4'hF) begin
               state_in = S_JUMP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_JUMP: begin
            col_in   = ord_rdata[SIDE_W-1:0];
            row_in   = ord_rdata[CELL_W-1:SIDE_W];
            tried_in = '0;
            if (bump) begin
               back_in = back_ff + COUNT_W'(1);
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         width_ff      <= CFG_W'(16);
         height_ff     <= CFG_W'(16);
         epoch_ff      <= TAG_CLEAR;
         clr_addr_ff   <= '0;
         start_pend_ff <= 1'b0;
         count_ff      <= '0;
         back_ff       <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         tried_ff      <= '0;
         running_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         epoch_ff      <= epoch_in;
         clr_addr_ff   <= clr_addr_in;
         start_pend_ff <= start_pend_in;
         count_ff      <= count_in;
         back_ff       <= back_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         tried_ff      <= tried_in;
         running_ff    <= running_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nc_ff       <= nc_in;
      nr_ff       <= nr_in;
      dir_ff      <= dir_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      emit && done_c |=> !running_ff)
      else $error("walker still running after the final cell");

   a_jump_origin: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_JUMP |-> $past(state_ff) == S_IDLE || $past(state_ff) == S_CHECK)
      else $error("back-jump entered from an unexpected state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CELLS))
      else $error("visit count beyond the grid");

   a_running_epoch: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> epoch_ff != TAG_CLEAR && count_ff != '0)
      else $error("running with no live epoch or empty visit order");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || !rsp_stall)
      else $error("result loaded over a stalled item");

endmodule

### rtl/core/rdfsmc_store.sv
// Visited-tag memory and visit-order memory, both with registered reads.
module rdfsmc_store (
   input  logic                                clock,
   input  rdfsmc_pkg::mem_cmd_type             cmd,
   output logic [rdfsmc_pkg::TAG_W-1:0]        tag_rdata,
   output logic [rdfsmc_pkg::CELL_W-1:0]       ord_rdata
);
   import rdfsmc_pkg::*;

   logic [TAG_W-1:0]  tag_mem [CELLS];
   logic [CELL_W-1:0] ord_mem [CELLS];

   always_ff @(posedge clock) begin
      if (cmd.tag_we) begin
         tag_mem[cmd.tag_waddr] <= cmd.tag_wdata;
      end
      tag_rdata <= tag_mem[cmd.tag_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ord_we) begin
         ord_mem[cmd.ord_waddr] <= cmd.ord_wdata;
      end
      ord_rdata <= ord_mem[cmd.ord_raddr];
   end

endmodule
